FILE: sv/spq_pkg.sv
package spq_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = 4;
  localparam int CNT_W = 5;

  localparam logic [1:0] OP_ADD  = 2'd0;
  localparam logic [1:0] OP_TAKE = 2'd1;
  localparam logic [1:0] OP_PEEK = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(DEPTH);

  typedef struct packed {
    logic [15:0] client;
    logic [7:0]  prio;
    logic [15:0] delay;
    logic [15:0] path;
  } rec_t;

  // best-so-far token that walks down the chain
  typedef struct packed {
    logic             live;
    logic             have;
    logic [IDX_W-1:0] pos;
    rec_t             rec;
  } tok_t;

  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_pos;
    logic             shift_en;
    logic [IDX_W-1:0] cut_pos;
    logic [CNT_W-1:0] count;
  } cell_ctrl_t;

endpackage

FILE: sv/spq_cell.sv
module spq_cell (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [spq_pkg::IDX_W-1:0] cell_idx,
  input  spq_pkg::cell_ctrl_t      ctrl,
  input  spq_pkg::rec_t            wr_rec,
  input  spq_pkg::rec_t            next_rec,
  input  spq_pkg::tok_t            tok_in,
  output spq_pkg::rec_t            rec_out,
  output spq_pkg::tok_t            tok_out
);

  spq_pkg::rec_t rec_r;
  spq_pkg::rec_t rec_nxt;
  spq_pkg::tok_t tok_r;
  spq_pkg::tok_t tok_nxt;
  logic          occupied;
  logic          wins;

  assign occupied = {1'b0, cell_idx} < ctrl.count;
  // strictly greater keeps the earliest arrival among equal priorities
  assign wins = tok_in.live && occupied &&
                (!tok_in.have || (rec_r.prio > tok_in.rec.prio));

  always_comb begin
    tok_nxt = tok_in;
    if (wins) begin
      tok_nxt.have = 1'b1;
      tok_nxt.pos  = cell_idx;
      tok_nxt.rec  = rec_r;
    end
  end

  always_comb begin
    priority if (ctrl.wr_en && (ctrl.wr_pos == cell_idx)) begin
      rec_nxt = wr_rec;
    end else if (ctrl.shift_en && (cell_idx >= ctrl.cut_pos)) begin
      // close the gap left by the removed request
      rec_nxt = next_rec;
    end else begin
      rec_nxt = rec_r;
    end
  end

  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.live <= 1'b0;
    end else begin
      tok_r.live <= tok_nxt.live;
    end
    tok_r.have <= tok_nxt.have;
    tok_r.pos  <= tok_nxt.pos;
    tok_r.rec  <= tok_nxt.rec;
  end

  assign rec_out = rec_r;
  assign tok_out = tok_r;

endmodule

FILE: sv/stable_priority_request_queue_core.sv
// Bounded priority queue of request records, built as a row of 16 cells.
// Input channel: a request (opcode, client, priority, delay, path) is taken
// at a clock edge with start high and busy low. Opcode add appends in
// arrival order, take removes the highest-priority record (earliest arrival
// among equals), peek reports that record's position.
// Result channel: out_valid marks each result for exactly one cycle; the
// receiver cannot stall it and must take it in that cycle.
// Request flow: add, unused opcode, and take/peek on an empty queue give
// their result in the cycle after acceptance, and the next request can
// follow in the very next cycle. Take and peek on a non-empty queue send a
// best-so-far token through all 16 cells, one cell per cycle; busy stays
// high until the token leaves the last cell, the result is registered from
// that cell's token, and no new request is taken while busy is high.
// Configuration: cfg_data (capacity in use) is written when cfg_valid is
// high; cfg_ready is always high. Write it only while the queue is idle.
// Reset (rst_n low, synchronous) empties the queue, sets capacity to 16 and
// drops busy and out_valid.
module stable_priority_request_queue_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_opcode,
  input  logic [15:0] in_client_handle,
  input  logic [7:0]  in_request_priority,
  input  logic [15:0] in_delay_value,
  input  logic [15:0] in_path_handle,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [15:0] out_client,
  output logic [7:0]  out_priority,
  output logic [15:0] out_delay,
  output logic [15:0] out_path,
  output logic [3:0]  out_best_position
);

  localparam int N = spq_pkg::DEPTH;

  logic [spq_pkg::CNT_W-1:0] count_r, count_nxt;
  logic [spq_pkg::CNT_W-1:0] cap_r;
  logic [spq_pkg::CNT_W-1:0] limit;
  logic                      scan_r;
  logic                      take_r;
  logic                      accept;
  logic                      is_add, is_take, is_peek;
  logic                      full, empty, add_ok, scan_go, finish;

  spq_pkg::cell_ctrl_t ctrl;
  spq_pkg::rec_t       wr_rec;
  spq_pkg::rec_t       rec_q [N];
  spq_pkg::tok_t       tok_q [N];
  spq_pkg::tok_t       tok_head;
  spq_pkg::tok_t       tail;

  logic                      out_valid_r;
  logic [1:0]                status_r;
  spq_pkg::rec_t             res_rec_r;
  logic [spq_pkg::IDX_W-1:0] pos_r;

  assign cfg_ready = 1'b1;
  assign busy      = scan_r;
  assign accept    = start && !scan_r;

  assign is_add  = in_opcode == spq_pkg::OP_ADD;
  assign is_take = in_opcode == spq_pkg::OP_TAKE;
  assign is_peek = in_opcode == spq_pkg::OP_PEEK;

  assign limit   = (cap_r > spq_pkg::CNT_W'(N)) ? spq_pkg::CNT_W'(N) : cap_r;
  assign full    = count_r >= limit;
  assign empty   = count_r == '0;
  assign add_ok  = accept && is_add && !full;
  assign scan_go = accept && (is_take || is_peek) && !empty;

  assign tail   = tok_q[N-1];
  assign finish = scan_r && tail.live;

  assign wr_rec = '{client: in_client_handle, prio: in_request_priority,
                    delay: in_delay_value, path: in_path_handle};

  always_comb begin
    ctrl.wr_en    = add_ok;
    ctrl.wr_pos   = count_r[spq_pkg::IDX_W-1:0];
    ctrl.shift_en = finish && take_r;
    ctrl.cut_pos  = tail.pos;
    ctrl.count    = count_r;
  end

  always_comb begin
    tok_head      = tail;
    tok_head.live = scan_go;
    tok_head.have = 1'b0;
  end

  for (genvar g = 0; g < N; g++) begin : g_cell
    spq_pkg::rec_t nb_rec;
    spq_pkg::tok_t nb_tok;
    if (g == N - 1) begin : g_last
      assign nb_rec = rec_q[g];
    end else begin : g_mid
      assign nb_rec = rec_q[g+1];
    end
    if (g == 0) begin : g_first
      assign nb_tok = tok_head;
    end else begin : g_rest
      assign nb_tok = tok_q[g-1];
    end
    spq_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (spq_pkg::IDX_W'(g)),
      .ctrl     (ctrl),
      .wr_rec   (wr_rec),
      .next_rec (nb_rec),
      .tok_in   (nb_tok),
      .rec_out  (rec_q[g]),
      .tok_out  (tok_q[g])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (add_ok) begin
      count_nxt = count_r + 1'b1;
    end else if (finish && take_r) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      cap_r       <= spq_pkg::CAP_RESET;
      scan_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_data;
      end
      if (scan_go) begin
        scan_r <= 1'b1;
      end else if (finish) begin
        scan_r <= 1'b0;
      end
      out_valid_r <= (accept && !scan_go) || finish;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      take_r <= is_take;
    end
    if (finish) begin
      status_r  <= spq_pkg::ST_OK;
      res_rec_r <= take_r ? tail.rec : '0;
      pos_r     <= take_r ? '0 : tail.pos;
    end else if (accept) begin
      res_rec_r <= '0;
      pos_r     <= '0;
      if (is_add && full) begin
        status_r <= spq_pkg::ST_FULL;
      end else if ((is_take || is_peek) && empty) begin
        status_r <= spq_pkg::ST_EMPTY;
      end else begin
        status_r <= spq_pkg::ST_OK;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_client        = res_rec_r.client;
  assign out_priority      = res_rec_r.prio;
  assign out_delay         = res_rec_r.delay;
  assign out_path          = res_rec_r.path;
  assign out_best_position = pos_r;

endmodule

FILE: sv/spq_checker.sv
module spq_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [1:0]  in_opcode,
  input logic        out_valid,
  input logic [1:0]  out_status,
  input logic [15:0] out_client,
  input logic [7:0]  out_priority
);

  // add gives its result in the next cycle and never holds off the next request
  a_add_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_opcode == spq_pkg::OP_ADD) |=> out_valid && !busy)
    else $error("add did not complete in one cycle");

  // take or peek either answers at once or goes busy
  a_scan_starts: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && ((in_opcode == spq_pkg::OP_TAKE) ||
    (in_opcode == spq_pkg::OP_PEEK)) |=> out_valid || busy)
    else $error("take/peek neither answered nor started a scan");

  // a scan always ends with exactly its result
  a_scan_ends: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid && (out_status == spq_pkg::ST_OK))
    else $error("scan ended without a result");

  a_no_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy && $past(busy) |-> !out_valid)
    else $error("result strobed during a scan");

  a_fail_is_blank: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != spq_pkg::ST_OK) |-> (out_client == '0) &&
    (out_priority == '0))
    else $error("failed request carried a record");

endmodule

bind stable_priority_request_queue_core spq_checker u_spq_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .in_opcode    (in_opcode),
  .out_valid    (out_valid),
  .out_status   (out_status),
  .out_client   (out_client),
  .out_priority (out_priority)
);

FILE: tb/tb.sv
module tb;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int PHASES = 10;
  localparam int ITEMS_PER_PHASE = 178;
  localparam int SETTLE_CYCLES = 24;

  typedef struct packed {
    logic [1:0]                status;
    spq_pkg::rec_t             rec;
    logic [spq_pkg::IDX_W-1:0] pos;
  } resp_t;

  class request_queue_mirror;
    spq_pkg::rec_t             slots[spq_pkg::DEPTH];
    int unsigned               held;
    logic [spq_pkg::CNT_W-1:0] cap;
    resp_t                     due[$];
    int                        errors;
    int                        adds, fulls, takes, peeks, empties, unused;

    function new();
      held = 0;
      cap = spq_pkg::CAP_RESET;
      errors = 0;
      adds = 0; fulls = 0; takes = 0; peeks = 0; empties = 0; unused = 0;
    endfunction

    function void set_capacity(logic [spq_pkg::CNT_W-1:0] v);
      cap = v;
    endfunction

    function int unsigned outstanding();
      return due.size();
    endfunction

    // first slot holding the top priority, so ties go to the oldest request
    function int unsigned best_slot();
      int unsigned b;
      b = 0;
      for (int unsigned i = 1; i < held; i++)
        if (slots[i].prio > slots[b].prio) b = i;
      return b;
    endfunction

    function void accept_request(logic [1:0] op, spq_pkg::rec_t r);
      resp_t       e;
      int unsigned lim;
      int unsigned b;
      e = '0;
      lim = (int'(cap) > spq_pkg::DEPTH) ? spq_pkg::DEPTH : int'(cap);
      case (op)
        spq_pkg::OP_ADD: begin
          if (held >= lim) begin
            e.status = spq_pkg::ST_FULL;
            fulls++;
          end else begin
            slots[held] = r;
            held++;
            adds++;
          end
        end
        spq_pkg::OP_TAKE: begin
          if (held == 0) begin
            e.status = spq_pkg::ST_EMPTY;
            empties++;
          end else begin
            b = best_slot();
            e.rec = slots[b];
            // close the gap behind the removed request
            for (int unsigned i = b; i + 1 < held; i++) slots[i] = slots[i + 1];
            held--;
            takes++;
          end
        end
        spq_pkg::OP_PEEK: begin
          if (held == 0) begin
            e.status = spq_pkg::ST_EMPTY;
            empties++;
          end else begin
            b = best_slot();
            e.pos = b[spq_pkg::IDX_W-1:0];
            peeks++;
          end
        end
        default: unused++;
      endcase
      due.push_back(e);
    endfunction

    task report(string what, logic [15:0] got, logic [15:0] want);
      errors++;
      $display("mismatch: %s got %0h expected %0h", what, got, want);
    endtask

    task check_response(resp_t got);
      resp_t e;
      if (due.size() == 0) begin
        report("result with no request outstanding", 16'(got.status), 16'd0);
        return;
      end
      e = due.pop_front();
      if (got.status != e.status)
        report("status", 16'(got.status), 16'(e.status));
      if (got.rec.client != e.rec.client)
        report("client", got.rec.client, e.rec.client);
      if (got.rec.prio != e.rec.prio)
        report("priority", 16'(got.rec.prio), 16'(e.rec.prio));
      if (got.rec.delay != e.rec.delay)
        report("delay", got.rec.delay, e.rec.delay);
      if (got.rec.path != e.rec.path)
        report("path", got.rec.path, e.rec.path);
      if (got.pos != e.pos)
        report("best position", 16'(got.pos), 16'(e.pos));
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_opcode;
  logic [15:0] in_client_handle;
  logic [7:0]  in_request_priority;
  logic [15:0] in_delay_value;
  logic [15:0] in_path_handle;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [4:0]  cfg_data;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [15:0] out_client;
  logic [7:0]  out_priority;
  logic [15:0] out_delay;
  logic [15:0] out_path;
  logic [3:0]  out_best_position;

  request_queue_mirror mirror = new();

  stable_priority_request_queue_core dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_opcode           (in_opcode),
    .in_client_handle    (in_client_handle),
    .in_request_priority (in_request_priority),
    .in_delay_value      (in_delay_value),
    .in_path_handle      (in_path_handle),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_data            (cfg_data),
    .out_valid           (out_valid),
    .out_status          (out_status),
    .out_client          (out_client),
    .out_priority        (out_priority),
    .out_delay           (out_delay),
    .out_path            (out_path),
    .out_best_position   (out_best_position)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    resp_t got;
    if (rst_n && out_valid) begin
      got.status     = out_status;
      got.rec.client = out_client;
      got.rec.prio   = out_priority;
      got.rec.delay  = out_delay;
      got.rec.path   = out_path;
      got.pos        = out_best_position;
      mirror.check_response(got);
    end
  end

  function automatic spq_pkg::rec_t random_record();
    spq_pkg::rec_t r;
    r.client = 16'($urandom);
    // mostly a few levels so ties are common
    r.prio   = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(3));
    r.delay  = 16'($urandom);
    r.path   = 16'($urandom);
    return r;
  endfunction

  function automatic logic [1:0] random_opcode(int add_weight);
    int r;
    r = $urandom_range(99);
    if (r < add_weight) return spq_pkg::OP_ADD;
    if (r >= 96) return OP_UNUSED;
    return (r % 3 == 0) ? spq_pkg::OP_PEEK : spq_pkg::OP_TAKE;
  endfunction

  // hold start high until the block takes the request
  task automatic send_request(logic [1:0] op, spq_pkg::rec_t r);
    @(negedge clk);
    start               = 1'b1;
    in_opcode           = op;
    in_client_handle    = r.client;
    in_request_priority = r.prio;
    in_delay_value      = r.delay;
    in_path_handle      = r.path;
    do @(posedge clk); while (busy);
    mirror.accept_request(op, r);
  endtask

  task automatic idle_cycles(int n);
    spq_pkg::rec_t noise;
    repeat (n) begin
      noise = random_record();
      @(negedge clk);
      start               = 1'b0;
      in_opcode           = 2'($urandom);
      in_client_handle    = noise.client;
      in_request_priority = noise.prio;
      in_delay_value      = noise.delay;
      in_path_handle      = noise.path;
      cfg_data            = 5'($urandom);
    end
  endtask

  task automatic drain();
    idle_cycles(1);
    while (mirror.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(logic [spq_pkg::CNT_W-1:0] v);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = v;
    do @(posedge clk); while (!cfg_ready);
    mirror.set_capacity(v);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    logic [spq_pkg::CNT_W-1:0] caps[PHASES];
    int                        add_weights[PHASES];
    spq_pkg::rec_t             ones;
    spq_pkg::rec_t             zeros;
    spq_pkg::rec_t             tie;
    bit                        quiet;

    caps        = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd7, 5'd17, 5'd16, 5'd2, 5'd12, 5'd16};
    add_weights = '{55, 60, 70, 50, 45, 65, 40, 55, 60, 35};
    ones  = '1;
    zeros = '0;
    tie   = '{client: 16'h1234, prio: 8'hFF, delay: 16'h5A5A, path: 16'hA5A5};

    clk                 = 1'b0;
    rst_n               = 1'b0;
    start               = 1'b0;
    in_opcode           = spq_pkg::OP_ADD;
    in_client_handle    = '0;
    in_request_priority = '0;
    in_delay_value      = '0;
    in_path_handle      = '0;
    cfg_valid           = 1'b0;
    cfg_data            = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: empty queue, unused opcode, ties, full, zero priority
    write_capacity(5'd3);
    send_request(spq_pkg::OP_TAKE, zeros);
    send_request(spq_pkg::OP_PEEK, ones);
    send_request(OP_UNUSED, ones);
    send_request(spq_pkg::OP_ADD, zeros);
    send_request(spq_pkg::OP_PEEK, zeros);
    send_request(spq_pkg::OP_ADD, ones);
    send_request(spq_pkg::OP_ADD, tie);
    send_request(spq_pkg::OP_ADD, ones);
    send_request(spq_pkg::OP_PEEK, zeros);
    send_request(spq_pkg::OP_TAKE, zeros);
    send_request(spq_pkg::OP_TAKE, zeros);
    send_request(spq_pkg::OP_TAKE, zeros);
    send_request(spq_pkg::OP_TAKE, zeros);
    send_request(spq_pkg::OP_ADD, tie);
    send_request(spq_pkg::OP_ADD, zeros);
    send_request(spq_pkg::OP_ADD, ones);
    drain();
    // shrink below the current fill level
    write_capacity(5'd1);
    send_request(spq_pkg::OP_ADD, ones);
    send_request(spq_pkg::OP_TAKE, zeros);
    send_request(spq_pkg::OP_TAKE, zeros);
    send_request(spq_pkg::OP_ADD, random_record());
    drain();

    for (int p = 0; p < PHASES; p++) begin
      write_capacity(caps[p]);
      quiet = (p == 6);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (!quiet && $urandom_range(99) < 25)
          idle_cycles(($urandom_range(7) == 0) ? $urandom_range(4, 20) : $urandom_range(1, 3));
        send_request(random_opcode(add_weights[p]), random_record());
      end
      // hold the sender until every result is back
      drain();
    end

    drain();
    if (mirror.outstanding() != 0)
      mirror.report("results never delivered", 16'(mirror.outstanding()), 16'd0);
    $display("covered %0d adds, %0d takes, %0d peeks and %0d unused opcodes",
             mirror.adds, mirror.takes, mirror.peeks, mirror.unused);
    $display("with %0d full and %0d empty refusals over %0d capacity settings",
             mirror.fulls, mirror.empties, PHASES + 2);
    if (mirror.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/spq_pkg.sv
sv/spq_cell.sv
sv/stable_priority_request_queue_core.sv
sv/spq_checker.sv
tb/tb.sv
